// ----- rtl/rpf_pkg.sv -----
// rpf_pkg: shared types and constants for the palette fade sequencer.
// No dependencies; used by rpf_palette, rpf_channel and the top module.
`default_nettype none
package rpf_pkg;

	localparam int LEVEL_W = 8;
	localparam int DUTY_W  = 10;
	localparam int INDEX_W = 3;
	localparam int NUM_CH  = 3;

	// channel slots inside an RGB word: red is the top byte
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [3:0] COUNT_MIN   = 4'd3;
	localparam logic [3:0] COUNT_RESET = 4'd3;

	typedef logic [NUM_CH-1:0][LEVEL_W-1:0] rgb_t;
	typedef logic [NUM_CH-1:0][DUTY_W-1:0]  duty_t;

endpackage
`default_nettype wire

// ----- rtl/rpf_palette.sv -----
// rpf_palette: palette storage, one write port and two registered read ports.
// Read data is write-first. Depends on rpf_pkg.
`default_nettype none
module rpf_palette #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [AW-1:0]       waddr,
	input  wire rpf_pkg::rgb_t       wdata,
	input  wire logic [AW-1:0]       raddr_a,
	input  wire logic [AW-1:0]       raddr_b,
	output rpf_pkg::rgb_t            rdata_a,
	output rpf_pkg::rgb_t            rdata_b
);

	rpf_pkg::rgb_t mem [DEPTH];
	rpf_pkg::rgb_t rd_a_q;
	rpf_pkg::rgb_t rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		rd_b_q <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule
`default_nettype wire

// ----- rtl/rpf_walk.sv -----
// rpf_walk: ping-pong walk step, gives the next position, direction and the
// from/to entries of a new segment. Pure logic, no package use.
`default_nettype none
module rpf_walk #(
	parameter int AW = 3,
	parameter int PW = 5
) (
	input  wire logic                 up_in,
	input  wire logic signed [PW-1:0] pos_in,
	input  wire logic signed [PW-1:0] count,
	output logic                      up_out,
	output logic signed [PW-1:0]      pos_out,
	output logic [AW-1:0]             from_idx,
	output logic [AW-1:0]             to_idx
);

	logic signed [PW-1:0] p;
	logic signed [PW-1:0] f;
	logic signed [PW-1:0] t;

	always_comb begin
		p       = up_in ? pos_in + PW'(1) : pos_in - PW'(1);
		up_out  = up_in;
		pos_out = p;
		f       = p;
		t       = p;
		if (up_in) begin
			if (p >= count) begin
				// ran past the end (count shrank): turn down
				up_out  = 1'b0;
				pos_out = count - PW'(2);
				f       = count - PW'(2);
				t       = count - PW'(3);
			end else if (p == count - PW'(1)) begin
				t = count - PW'(2);
			end else begin
				t = p + PW'(1);
			end
		end else begin
			if (p <= -PW'(1)) begin
				up_out  = 1'b1;
				pos_out = PW'(1);
				f       = PW'(1);
				t       = PW'(2);
			end else if (p == PW'(0)) begin
				t = PW'(1);
			end else begin
				t = p - PW'(1);
			end
		end
		from_idx = AW'(f);
		to_idx   = AW'(t);
	end

endmodule
`default_nettype wire

// ----- rtl/rpf_channel.sv -----
// rpf_channel: one color channel, steps the level by one toward the goal and
// rescales it to a PWM compare value. Depends on rpf_pkg.
`default_nettype none
module rpf_channel #(
	parameter int PWM_TOP = 999
) (
	input  wire logic [rpf_pkg::LEVEL_W-1:0] level,
	input  wire logic [rpf_pkg::LEVEL_W-1:0] goal,
	input  wire logic [rpf_pkg::DUTY_W-1:0]  duty,
	output logic [rpf_pkg::LEVEL_W-1:0]      level_next,
	output logic [rpf_pkg::DUTY_W-1:0]       duty_next,
	output logic                             at_goal
);

	// level*TOP/255 = level*(TOP/255) + level*(TOP%255)/255; second part < 2^16
	localparam int unsigned A_MUL = PWM_TOP / 255;
	localparam int unsigned B_MUL = PWM_TOP % 255;

	logic [16:0] prod_a;
	logic [15:0] prod_b;
	logic [16:0] div_t;
	logic [16:0] scaled;

	always_comb begin
		if (level < goal) begin
			level_next = level + rpf_pkg::LEVEL_W'(1);
		end else if (level > goal) begin
			level_next = level - rpf_pkg::LEVEL_W'(1);
		end else begin
			level_next = level;
		end
	end

	// exact floor(y/255) for y < 65535: (y + 1 + (y >> 8)) >> 8
	assign prod_a = 17'(level_next) * 17'(A_MUL);
	assign prod_b = 16'(level_next) * 16'(B_MUL);
	assign div_t  = 17'(prod_b) + 17'd1 + 17'(prod_b[15:8]);
	assign scaled = prod_a + 17'(div_t[16:8]);

	assign duty_next = (level != goal) ? scaled[rpf_pkg::DUTY_W-1:0] : duty;
	assign at_goal   = (level_next == goal);

endmodule
`default_nettype wire

// ----- rtl/rgb_palette_fade_sequencer.sv -----
// Palette fade sequencer: ping-pong color walk over a palette, three PWM channels.
// A tick beat is captured in the input stage, then its result is registered in the
// state registers on m_*. One beat per cycle, ticks and palette writes alike, unless
// a tick waits on m_tready; a config write holds processing while read ports refetch.
// Reset (arst_n low, async): walk restarts, levels/duty/count cleared to defaults;
// palette RAM is not cleared and reads as garbage until written.
`default_nettype none
module rgb_palette_fade_sequencer #(
	parameter int PALETTE_DEPTH = 8,
	parameter int PWM_TOP       = 999
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [2:0] entry_index, [10:3] entry_red, [18:11] entry_green,
	// [26:19] entry_blue, [31:27] zero
	input  wire logic [31:0] s_tdata,
	// [0] operation
	input  wire logic        s_tuser,
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [9:0] pwm_red, [19:10] pwm_green, [29:20] pwm_blue,
	// [32:30] from_entry, [35:33] to_entry, [39:36] zero
	output logic [39:0]      m_tdata,
	// segment_finished
	output logic             m_tlast,
	// color_count register
	input  wire logic        cfg_wen,
	input  wire logic [3:0]  cfg_wdata
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int PW = $clog2(PALETTE_DEPTH + 1) + 1;  // signed walk position
	localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

	// entry_index mod depth; index < 8 and depth >= 3 so two folds suffice
	function automatic logic [AW-1:0] wrap_index(input logic [2:0] idx);
		logic [8:0] v;
		v = 9'(idx);
		if (v >= DEPTH9) begin
			v = v - DEPTH9;
		end
		if (v >= DEPTH9) begin
			v = v - DEPTH9;
		end
		return AW'(v);
	endfunction

	// input stage
	logic                             valid_s1;
	logic                             op_s1;
	logic [rpf_pkg::INDEX_W-1:0]      idx_s1;
	rpf_pkg::rgb_t                    rgb_s1;

	// config
	logic [3:0]                       count_q;
	logic                             cfg_hold_q;
	logic [8:0]                       cnt9;
	logic signed [PW-1:0]             cnt_eff;

	// walk / fade state; duty, entries and seg_over double as the result register
	logic signed [PW-1:0]             pos_q, pos_d;
	logic                             up_q, up_d;
	logic                             seg_over_q, seg_over_d;
	logic [AW-1:0]                    src_q, src_d;
	logic [AW-1:0]                    tgt_q, tgt_d;
	rpf_pkg::rgb_t                    level_q, level_d;
	rpf_pkg::duty_t                   duty_q, duty_d;
	logic                             m_tvalid_q;

	// walk results
	logic                             w_up;
	logic signed [PW-1:0]             w_pos;
	logic [AW-1:0]                    w_from, w_to;
	logic [AW-1:0]                    n_from, n_to;

	// palette
	logic [AW-1:0]                    addr_a, addr_b;
	rpf_pkg::rgb_t                    rd_src, rd_tgt;

	// datapath
	logic                             process;
	logic                             do_tick;
	logic                             do_write;
	rpf_pkg::rgb_t                    base_level;
	rpf_pkg::rgb_t                    lvl_n;
	rpf_pkg::duty_t                   duty_n;
	logic [rpf_pkg::NUM_CH-1:0]       match;

	// handshake: with no config hold, s1 drains when a write, or when the result slot is free
	assign process  = valid_s1 && !cfg_hold_q &&
		(op_s1 == rpf_pkg::OP_WRITE || !m_tvalid_q || m_tready);
	assign do_tick  = process && (op_s1 == rpf_pkg::OP_TICK);
	assign do_write = process && (op_s1 == rpf_pkg::OP_WRITE);
	assign s_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser;
			idx_s1 <= s_tdata[2:0];
			rgb_s1 <= {s_tdata[10:3], s_tdata[18:11], s_tdata[26:19]};
		end
	end

	// color_count; clamp to 3..depth before use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= rpf_pkg::COUNT_RESET;
			cfg_hold_q <= 1'b0;
		end else begin
			cfg_hold_q <= cfg_wen;
			if (cfg_wen) begin
				count_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		cnt9 = 9'(count_q);
		if (cnt9 < 9'(rpf_pkg::COUNT_MIN)) begin
			cnt9 = 9'(rpf_pkg::COUNT_MIN);
		end
		if (cnt9 > DEPTH9) begin
			cnt9 = DEPTH9;
		end
	end
	assign cnt_eff = PW'(cnt9);

	// segment start plan from the current walk state
	rpf_walk #(.AW(AW), .PW(PW)) u_walk_now (
		.up_in    (up_q),
		.pos_in   (pos_q),
		.count    (cnt_eff),
		.up_out   (w_up),
		.pos_out  (w_pos),
		.from_idx (w_from),
		.to_idx   (w_to)
	);

	// new segment: levels come from the 'from' entry, else carry on
	assign base_level = seg_over_q ? rd_src : level_q;

	for (genvar c = 0; c < rpf_pkg::NUM_CH; c++) begin : g_ch
		rpf_channel #(.PWM_TOP(PWM_TOP)) u_ch (
			.level      (base_level[c]),
			.goal       (rd_tgt[c]),
			.duty       (duty_q[c]),
			.level_next (lvl_n[c]),
			.duty_next  (duty_n[c]),
			.at_goal    (match[c])
		);
	end

	always_comb begin
		pos_d      = pos_q;
		up_d       = up_q;
		seg_over_d = seg_over_q;
		src_d      = src_q;
		tgt_d      = tgt_q;
		level_d    = level_q;
		duty_d     = duty_q;
		if (do_tick) begin
			if (seg_over_q) begin
				pos_d = w_pos;
				up_d  = w_up;
				src_d = w_from;
				tgt_d = w_to;
			end
			level_d    = lvl_n;
			duty_d     = duty_n;
			seg_over_d = &match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= -PW'(1);
			up_q       <= 1'b1;
			seg_over_q <= 1'b1;
			src_q      <= '0;
			tgt_q      <= '0;
			level_q    <= '0;
			duty_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			pos_q      <= pos_d;
			up_q       <= up_d;
			seg_over_q <= seg_over_d;
			src_q      <= src_d;
			tgt_q      <= tgt_d;
			level_q    <= level_d;
			duty_q     <= duty_d;
			if (do_tick) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// prefetch for the next tick: plan from the post-edge walk state
	rpf_walk #(.AW(AW), .PW(PW)) u_walk_next (
		.up_in    (up_d),
		.pos_in   (pos_d),
		.count    (cnt_eff),
		.up_out   (),
		.pos_out  (),
		.from_idx (n_from),
		.to_idx   (n_to)
	);

	assign addr_a = n_from;
	assign addr_b = seg_over_d ? n_to : tgt_d;

	rpf_palette #(.DEPTH(PALETTE_DEPTH), .AW(AW)) u_palette (
		.clk     (clk),
		.we      (do_write),
		.waddr   (wrap_index(idx_s1)),
		.wdata   (rgb_s1),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_src),
		.rdata_b (rd_tgt)
	);

	// result beat straight from the state registers; they hold while stalled
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = seg_over_q;
	assign m_tdata  = {4'd0, 3'(tgt_q), 3'(src_q),
		duty_q[rpf_pkg::CH_BLUE], duty_q[rpf_pkg::CH_GREEN], duty_q[rpf_pkg::CH_RED]};

endmodule
`default_nettype wire

// ----- rtl/rpf_checker.sv -----
// rpf_checker: port-level assertions for the fade sequencer, bound to the top.
// Depends on rgb_palette_fade_sequencer port layout.
`default_nettype none
module rpf_checker #(
	parameter int PWM_TOP = 999
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);

	localparam logic [9:0] DUTY_MAX = (PWM_TOP > 1023) ? 10'h3FF : 10'(PWM_TOP);

	logic [2:0] from_e, to_e;
	logic       open_q;
	logic [2:0] from_last_q, to_last_q;

	assign from_e = m_tdata[32:30];
	assign to_e   = m_tdata[35:33];

	// track the segment of the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			open_q <= !m_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			from_last_q <= from_e;
			to_last_q   <= to_e;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (3'(from_e + 3'd1) == to_e) || (3'(to_e + 3'd1) == from_e))
		else $error("from/to entries not adjacent");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:0] <= DUTY_MAX && m_tdata[19:10] <= DUTY_MAX &&
			m_tdata[29:20] <= DUTY_MAX)
		else $error("duty above PWM top");

	a_segment_kept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && open_q |-> from_e == from_last_q && to_e == to_last_q)
		else $error("segment changed before it finished");

endmodule

bind rgb_palette_fade_sequencer rpf_checker #(.PWM_TOP(PWM_TOP)) u_rpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
